>>> hdl/bfsp_pkg.sv
// Shared constants, types and controller/datapath command and status structs.
package bfsp_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 6;
    localparam int BITS_W      = 4;
    localparam int PCNT_W      = 3;
    localparam int SUM_W       = LEN_W + 1;
    localparam int NBYTES_MAX  = VALUE_WIDTH / BYTE_W;
    localparam int CHUNK_W     = (NBYTES_MAX > 1) ? $clog2(NBYTES_MAX) : 1;
    localparam int NB_W        = $clog2(NBYTES_MAX + 1);
    localparam int RES_W       = $clog2(NBYTES_MAX + 2);

    localparam logic MODE_INT = 1'b0;
    localparam logic MODE_RAW = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ERR   = 4'b0010,
        S_PUSH  = 4'b0100,
        S_FLUSH = 4'b1000
    } t_state;

    typedef struct packed {
        logic load;
        logic push;
        logic emit_err;
        logic emit_flush;
    } t_cmd;

    typedef struct packed {
        logic in_bad;
        logic in_nochunk;
        logic chunk_last;
        logic flush_pend;
        logic flush_req;
        logic out_free;
    } t_status;

endpackage

>>> hdl/bfsp_if.sv
// Valid/ready channel interfaces for field input and byte output.
interface bfsp_in_if;
    import bfsp_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   mode;
    logic [VALUE_WIDTH-1:0] field_value;
    logic [LEN_W-1:0]       bit_length;
    logic                   flush;

    modport source (output valid, mode, field_value, bit_length, flush, input ready);
    modport sink   (input valid, mode, field_value, bit_length, flush, output ready);
endinterface

interface bfsp_out_if;
    import bfsp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic [BITS_W-1:0] out_bits;
    logic              error;
    logic              last;

    modport source (output valid, out_byte, out_bits, error, last, input ready);
    modport sink   (input valid, out_byte, out_bits, error, last, output ready);
endinterface

>>> hdl/bfsp_ctrl.sv
// Sequencing state machine: accept, error report, per-byte push, flush.
module bfsp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  bfsp_pkg::t_status i_status,
    output bfsp_pkg::t_cmd    o_cmd,
    output logic              o_in_ready
);
    import bfsp_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_status.in_bad) begin
                        n_state = S_ERR;
                    end else if (i_status.in_nochunk) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_state = S_PUSH;
                    end
                end
            end
            S_ERR: begin
                if (i_status.out_free) begin
                    o_cmd.emit_err = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_PUSH: begin
                // stall while the output register is held by the receiver
                if (i_status.out_free) begin
                    o_cmd.push = 1'b1;
                    if (i_status.chunk_last) begin
                        n_state = i_status.flush_pend ? S_FLUSH : S_IDLE;
                    end
                end
            end
            S_FLUSH: begin
                if (!i_status.flush_req) begin
                    n_state = S_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.emit_flush = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/bfsp_dp.sv
// Datapath: field capture, range check, bit packer, result counter, output register.
module bfsp_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  bfsp_pkg::t_cmd                   i_cmd,
    output bfsp_pkg::t_status                o_status,
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_wdata,
    input  logic                             i_mode,
    input  logic [bfsp_pkg::VALUE_WIDTH-1:0] i_field_value,
    input  logic [bfsp_pkg::LEN_W-1:0]       i_bit_length,
    input  logic                             i_flush,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic [bfsp_pkg::BYTE_W-1:0]      o_out_byte,
    output logic [bfsp_pkg::BITS_W-1:0]      o_out_bits,
    output logic                             o_error,
    output logic                             o_last
);
    import bfsp_pkg::*;

    // config and captured transaction
    logic                   r_le;
    logic [VALUE_WIDTH-1:0] r_val;
    logic [NB_W-1:0]        r_nbytes;
    logic [BITS_W-1:0]      r_top;
    logic                   r_flush;
    logic [RES_W-1:0]       r_total;
    logic [RES_W-1:0]       r_rcnt;
    logic [CHUNK_W-1:0]     r_chunk;
    // packer state
    logic [BYTE_W-1:0]      r_pb;
    logic [PCNT_W-1:0]      r_pc;
    // output register
    logic                   r_ovalid;
    logic [BYTE_W-1:0]      r_obyte;
    logic [BITS_W-1:0]      r_obits;
    logic                   r_oerr;
    logic                   r_olast;

    // input side
    logic [LEN_W-1:0]       l_eff;
    logic [SUM_W-1:0]       in_sum;
    logic [SUM_W-1:0]       len_rnd;
    logic [NB_W-1:0]        in_nbytes;
    logic [BITS_W-1:0]      in_top;
    logic [RES_W-1:0]       in_total;
    logic                   in_bad;
    // push side
    logic [NB_W-1:0]        nb_m1;
    logic [CHUNK_W-1:0]     idx;
    logic [BYTE_W-1:0]      sel_byte;
    logic [BITS_W-1:0]      k;
    logic [BYTE_W:0]        mask9;
    logic [BITS_W-1:0]      shamt;
    logic [BITS_W-1:0]      take;
    logic [BYTE_W-1:0]      aligned;
    logic [BYTE_W-1:0]      merged;
    logic [2*BYTE_W-1:0]    rem_w;
    logic [BITS_W-1:0]      psum;
    logic                   full;
    logic                   out_free;
    logic                   is_last;

    always_comb begin
        in_bad = (i_mode == MODE_INT) &&
                 ((i_bit_length == '0) ||
                  (i_bit_length > LEN_W'(VALUE_WIDTH)) ||
                  ((i_field_value >> i_bit_length) != '0));
        if (i_mode == MODE_RAW) begin
            l_eff = (i_bit_length > LEN_W'(BYTE_W)) ? LEN_W'(BYTE_W) : i_bit_length;
        end else begin
            l_eff = i_bit_length;
        end
        len_rnd = SUM_W'(i_bit_length) + SUM_W'(BYTE_W - 1);
        if (i_mode == MODE_RAW) begin
            in_nbytes = NB_W'(l_eff != '0);
            in_top    = l_eff[BITS_W-1:0];
        end else begin
            in_nbytes = NB_W'(len_rnd >> 3);
            in_top    = (i_bit_length[2:0] == 3'd0) ? BITS_W'(BYTE_W)
                                                    : {1'b0, i_bit_length[2:0]};
        end
        in_sum   = SUM_W'(r_pc) + SUM_W'(l_eff);
        in_total = RES_W'(in_sum >> 3) + RES_W'(i_flush && (in_sum[2:0] != 3'd0));
    end

    always_comb begin
        nb_m1    = r_nbytes - NB_W'(1);
        idx      = r_le ? r_chunk : (nb_m1[CHUNK_W-1:0] - r_chunk);
        sel_byte = r_val[{idx, 3'b000} +: BYTE_W];
        k        = ({{(NB_W-CHUNK_W){1'b0}}, idx} == nb_m1) ? r_top : BITS_W'(BYTE_W);
        mask9    = ((BYTE_W+1)'(1) << k) - (BYTE_W+1)'(1);
        shamt    = BITS_W'(BYTE_W) - k;
        aligned  = BYTE_W'((sel_byte & mask9[BYTE_W-1:0]) << shamt[2:0]);
        merged   = r_pb | (aligned >> r_pc);
        psum     = BITS_W'(r_pc) + k;
        full     = psum[3];
        take     = BITS_W'(BYTE_W) - BITS_W'(r_pc);
        rem_w    = (2*BYTE_W)'(aligned) << take;
        out_free = !r_ovalid || i_out_ready;
        is_last  = (r_rcnt == (r_total - RES_W'(1)));
    end

    always_comb begin
        o_status            = '0;
        o_status.in_bad     = in_bad;
        o_status.in_nochunk = (i_mode == MODE_RAW) && (l_eff == '0);
        o_status.chunk_last = ({{(NB_W-CHUNK_W){1'b0}}, r_chunk} == nb_m1);
        o_status.flush_pend = r_flush;
        o_status.flush_req  = r_flush && (r_pc != '0);
        o_status.out_free   = out_free;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_le     <= 1'b0;
            r_pb     <= '0;
            r_pc     <= '0;
            r_ovalid <= 1'b0;
            r_chunk  <= '0;
            r_rcnt   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_le <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                r_chunk <= '0;
                r_rcnt  <= '0;
            end
            if (i_cmd.push) begin
                r_chunk <= r_chunk + CHUNK_W'(1);
                r_pc    <= psum[2:0];
                if (full) begin
                    r_pb   <= rem_w[BYTE_W-1:0];
                    r_rcnt <= r_rcnt + RES_W'(1);
                end else begin
                    r_pb <= merged;
                end
            end
            if (i_cmd.emit_flush) begin
                r_pb   <= '0;
                r_pc   <= '0;
                r_rcnt <= r_rcnt + RES_W'(1);
            end
            if ((i_cmd.push && full) || i_cmd.emit_flush || i_cmd.emit_err) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_val    <= i_field_value;
            r_nbytes <= in_nbytes;
            r_top    <= in_top;
            r_flush  <= i_flush;
            r_total  <= in_total;
        end
        if (i_cmd.push && full) begin
            r_obyte <= merged;
            r_obits <= BITS_W'(BYTE_W);
            r_oerr  <= 1'b0;
            r_olast <= is_last;
        end else if (i_cmd.emit_flush) begin
            r_obyte <= r_pb;
            r_obits <= BITS_W'(r_pc);
            r_oerr  <= 1'b0;
            r_olast <= is_last;
        end else if (i_cmd.emit_err) begin
            r_obyte <= '0;
            r_obits <= '0;
            r_oerr  <= 1'b1;
            r_olast <= 1'b1;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_byte  = r_obyte;
    assign o_out_bits  = r_obits;
    assign o_error     = r_oerr;
    assign o_last      = r_olast;

endmodule

>>> hdl/bit_field_stream_packer.sv
// Top level of the MSB-first bit field stream packer.
//
// Usage:
//   i_in  (sink)  : one transaction per field: mode, field_value, bit_length, flush.
//   o_out (source): one transaction per packed byte: out_byte (left aligned),
//                   out_bits, error, last (set on the final result of a field).
//   i_cfg_we / i_cfg_wdata : little_endian byte order bit, write only while idle.
// Sequence:
//   A field is accepted in the idle state, then the packer pushes one byte chunk
//   per cycle while the output register is free (1..4 for an integer, 0 or 1 for
//   raw), then, for a flush request, emits any pending partial byte.
//   A byte result is registered and shows in the cycle after the push that
//   completes it, so the first one follows the first push, later when the first
//   chunk does not fill a byte.
//   A range error gives one result, from the error state.
// Stall: results go through a single output register; the push loop waits
//   whenever that register is full and not being taken, so nothing is dropped.
// Reset: synchronous active-low i_rst_n clears the pending partial byte, the
//   byte order register (big endian) and the output valid.
module bit_field_stream_packer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    bfsp_in_if.sink     i_in,
    bfsp_out_if.source  o_out
);
    import bfsp_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    in_ready;

    bfsp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_ready (in_ready)
    );

    bfsp_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_mode        (i_in.mode),
        .i_field_value (i_in.field_value),
        .i_bit_length  (i_in.bit_length),
        .i_flush       (i_in.flush),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_out_byte    (o_out.out_byte),
        .o_out_bits    (o_out.out_bits),
        .o_error       (o_out.error),
        .o_last        (o_out.last)
    );

    // input transaction is taken only in the idle state
    assign i_in.ready = in_ready;

endmodule

>>> sim/bit_field_stream_packer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the bit field stream packer: directed and random fields.
module bit_field_stream_packer_tb;
    import bfsp_pkg::*;

    localparam int CLK_HALF      = 6;     // 12 ns period
    localparam int RESET_CYCLES  = 5;
    localparam int STALL_LIMIT   = 2000;  // cycles with no transaction on either side
    localparam int SETTLE_CYCLES = 10;    // covers the longest item with margin
    localparam int SEGMENTS      = 6;     // three idling phases, two byte orders each
    localparam int SEG_FIELDS    = 43;    // about 280 fields in total with the directed ones

    localparam logic ORDER_BIG    = 1'b0;
    localparam logic ORDER_LITTLE = 1'b1;

    typedef struct packed {
        logic                   mode;
        logic [VALUE_WIDTH-1:0] value;
        logic [LEN_W-1:0]       len;
        logic                   flush;
    } t_field;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic [BITS_W-1:0] out_bits;
        logic              error;
        logic              last;
    } t_packed_byte;

    // Tracks the packer state and the bytes it owes us, in order.
    class byte_stream_predictor;
        logic              little_endian;
        logic [BYTE_W-1:0] partial_byte;
        int                partial_count;
        t_packed_byte      expected_bytes[$];
        int                failures;

        function void clear();
            little_endian = ORDER_BIG;
            partial_byte  = '0;
            partial_count = 0;
            expected_bytes.delete();
            failures      = 0;
        endfunction

        function void set_order(logic le);
            little_endian = le;
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        function void emit(logic [BYTE_W-1:0] b, int bits, logic err);
            t_packed_byte r;
            r.out_byte = b;
            r.out_bits = BITS_W'(bits);
            r.error    = err;
            r.last     = 1'b0;
            expected_bytes = {expected_bytes, r};
        endfunction

        // Append the low k bits (1..8) of v, MSB first; a completed byte goes out.
        function void append_bits(logic [BYTE_W-1:0] v, int k);
            logic [BYTE_W-1:0] aligned;
            int                take;
            aligned = 8'((int'(v) & ((1 << k) - 1)) << (8 - k));
            take    = (k < 8 - partial_count) ? k : 8 - partial_count;
            partial_byte  = partial_byte | (aligned >> partial_count);
            partial_count = partial_count + take;
            if (partial_count == 8) begin
                emit(partial_byte, 8, 1'b0);
                partial_byte  = 8'(aligned << take);
                partial_count = k - take;
            end
        endfunction

        function void note_field(t_field f);
            int           n0;
            int           len;
            int           nbytes;
            int           top;
            int           idx;
            logic         bad;
            n0  = expected_bytes.size();
            len = int'(f.len);
            bad = (f.mode == MODE_INT) &&
                  ((len == 0) || (len > VALUE_WIDTH) || ((f.value >> len) != 0));
            if (bad) begin
                // rejected integer: one error byte, state and flush untouched
                emit('0, 0, 1'b1);
            end else begin
                if (f.mode == MODE_INT) begin
                    nbytes = (len + 7) / 8;
                    top    = ((len - 1) % 8) + 1;
                    for (int i = 0; i < nbytes; i++) begin
                        idx = little_endian ? i : (nbytes - 1 - i);
                        append_bits(8'(f.value >> (8 * idx)),
                                    (idx == nbytes - 1) ? top : 8);
                    end
                end else begin
                    if (len > BYTE_W)
                        len = BYTE_W;
                    if (len != 0)
                        append_bits(f.value[BYTE_W-1:0], len);
                end
                if (f.flush && partial_count != 0) begin
                    emit(partial_byte, partial_count, 1'b0);
                    partial_byte  = '0;
                    partial_count = 0;
                end
            end
            if (expected_bytes.size() > n0)
                expected_bytes[expected_bytes.size() - 1].last = 1'b1;
        endfunction

        function void check_byte(t_packed_byte got);
            t_packed_byte want;
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected byte %h bits %0d error %b last %b",
                         $time, got.out_byte, got.out_bits, got.error, got.last);
                failures++;
            end else begin
                want = expected_bytes.pop_front();
                if (got.out_byte !== want.out_byte) begin
                    $display("%0t: out_byte expected %h actual %h",
                             $time, want.out_byte, got.out_byte);
                    failures++;
                end
                if (got.out_bits !== want.out_bits) begin
                    $display("%0t: out_bits expected %0d actual %0d",
                             $time, want.out_bits, got.out_bits);
                    failures++;
                end
                if (got.error !== want.error) begin
                    $display("%0t: error expected %b actual %b",
                             $time, want.error, got.error);
                    failures++;
                end
                if (got.last !== want.last) begin
                    $display("%0t: last expected %b actual %b",
                             $time, want.last, got.last);
                    failures++;
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic cfg_we;
    logic cfg_wdata;

    int send_idle_pct;
    int recv_idle_pct;
    int quiet_cycles = 0;

    byte_stream_predictor predictor;

    bfsp_in_if  in_if ();
    bfsp_out_if out_if ();

    bit_field_stream_packer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Output side: sample the transaction seen at this edge, then pick the
    // ready for the next cycle. Values read here are the pre-edge ones, so no
    // race with the block's own updates.
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            predictor.check_byte({out_if.out_byte, out_if.out_bits,
                                  out_if.error, out_if.last});
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: any transaction on either channel restarts the count.
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("bit_field_stream_packer: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_field field_of(logic mode, logic [VALUE_WIDTH-1:0] value,
                                        int len, logic flush);
        t_field f;
        f.mode  = mode;
        f.value = value;
        f.len   = LEN_W'(len);
        f.flush = flush;
        return f;
    endfunction

    // Mostly well-formed fields with random content; the rest are range
    // errors and junk fields of either mode.
    function automatic t_field random_field();
        t_field                 f;
        int                     r;
        int                     len;
        logic [VALUE_WIDTH-1:0] mask;
        r       = $urandom_range(99);
        f.flush = ($urandom_range(99) < 30);
        f.value = $urandom;
        if (r < 45) begin
            // integer that fits
            f.mode = MODE_INT;
            len    = $urandom_range(VALUE_WIDTH, 1);
            mask   = '1;
            mask   = mask >> (VALUE_WIDTH - len);
            f.value = f.value & mask;
        end else if (r < 75) begin
            // raw byte, now and then with a length that saturates
            f.mode = MODE_RAW;
            len    = ($urandom_range(9) == 0) ? $urandom_range(63, 9) : $urandom_range(8, 0);
        end else if (r < 90) begin
            // integer that must be rejected
            f.mode = MODE_INT;
            case ($urandom_range(2))
                0: begin
                    len = 0;
                end
                1: begin
                    len = $urandom_range(63, VALUE_WIDTH + 1);
                end
                default: begin
                    len     = $urandom_range(VALUE_WIDTH - 1, 1);
                    f.value = f.value | (32'h1 << $urandom_range(VALUE_WIDTH - 1, len));
                end
            endcase
        end else begin
            f.mode = 1'($urandom_range(1));
            len    = $urandom_range(63);
        end
        f.len = LEN_W'(len);
        return f;
    endfunction

    // One input transaction, with random idle cycles in front. valid stays
    // high after acceptance; the next call or the caller lowers it.
    task automatic send_field(input t_field f);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.mode        <= f.mode;
        in_if.field_value <= f.value;
        in_if.bit_length  <= f.len;
        in_if.flush       <= f.flush;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        predictor.note_field(f);
    endtask

    // Byte order write: only once all owed bytes are out and any field that
    // produced nothing has had time to finish inside the block.
    task automatic write_order(input logic le);
        in_if.valid <= 1'b0;
        while (predictor.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= le;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        predictor.set_order(le);
    endtask

    initial begin
        predictor = new;
        predictor.clear();

        i_rst_n           = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = 1'b0;
        in_if.valid       = 1'b0;
        in_if.mode        = MODE_INT;
        in_if.field_value = '0;
        in_if.bit_length  = '0;
        in_if.flush       = 1'b0;
        out_if.ready      = 1'b0;
        send_idle_pct     = 25;
        recv_idle_pct     = 57;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, big endian
        write_order(ORDER_BIG);
        send_field(field_of(MODE_INT, 32'hFFFF_FFFF, 32, 1'b0)); // full width
        send_field(field_of(MODE_INT, 32'h0000_0000, 0, 1'b0));  // zero length
        send_field(field_of(MODE_INT, 32'h0000_0100, 8, 1'b0));  // value too large
        send_field(field_of(MODE_INT, 32'h0000_0005, 40, 1'b1)); // length above width
        send_field(field_of(MODE_INT, 32'h0000_0001, 1, 1'b0));
        send_field(field_of(MODE_RAW, 32'h0000_00FF, 0, 1'b1));  // raw zero length, flush
        send_field(field_of(MODE_RAW, 32'hFFFF_FFA5, 63, 1'b0)); // raw saturates
        send_field(field_of(MODE_RAW, 32'h0000_003C, 3, 1'b0));  // raw masked
        send_field(field_of(MODE_INT, 32'h0000_0002, 1, 1'b1));  // error with bits pending
        send_field(field_of(MODE_INT, 32'h0001_2345, 17, 1'b1));
        send_field(field_of(MODE_RAW, 32'h0000_0000, 0, 1'b1));  // flush, nothing pending
        send_field(field_of(MODE_INT, 32'h0000_0000, 32, 1'b0));
        send_field(field_of(MODE_INT, 32'h0000_007F, 7, 1'b1));

        // Directed, little endian
        write_order(ORDER_LITTLE);
        send_field(field_of(MODE_INT, 32'hDEAD_BEEF, 32, 1'b0));
        send_field(field_of(MODE_INT, 32'h0001_ABCD, 17, 1'b1));
        send_field(field_of(MODE_INT, 32'h8000_0000, 31, 1'b0));
        send_field(field_of(MODE_RAW, 32'h0000_0001, 5, 1'b0));
        send_field(field_of(MODE_INT, 32'h0000_03FF, 10, 1'b1));
        send_field(field_of(MODE_RAW, 32'h0000_00FF, 8, 1'b1));
        send_field(field_of(MODE_INT, 32'hFFFF_FFFF, 63, 1'b1));
        send_field(field_of(MODE_INT, 32'h0000_0000, 0, 1'b1));
        send_field(field_of(MODE_INT, 32'h7FFF_FFFF, 31, 1'b1));

        // Random: receiver busy / sender busy / no idling, both orders each
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg / 2)
                0: begin
                    send_idle_pct = 25;
                    recv_idle_pct = 57;
                end
                1: begin
                    send_idle_pct = 57;
                    recv_idle_pct = 25;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            write_order((seg % 2) ? ORDER_LITTLE : ORDER_BIG);
            repeat (SEG_FIELDS) send_field(random_field());
        end

        in_if.valid <= 1'b0;
        while (predictor.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (predictor.failures == 0 && predictor.pending() == 0)
            $display("bit_field_stream_packer: match");
        else
            $display("bit_field_stream_packer: mismatch");
        $finish;
    end

endmodule
